### rtl/ihex_pkg.sv
package ihex_pkg;

	localparam int PAGE_BYTES_DEF = 2048;
	localparam int MAX_LINE_CHARS_DEF = 60;
	localparam int RECORD_BUF_BYTES_DEF = 30;
	localparam int RESULT_ROOM = 26;

	localparam logic [1:0] FUNC_CHAR = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_END = 2'd2;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_PAGE = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [3:0] ST_OK = 4'd0;
	localparam logic [3:0] ST_NO_COLON = 4'd1;
	localparam logic [3:0] ST_SHORT = 4'd2;
	localparam logic [3:0] ST_LONG = 4'd3;
	localparam logic [3:0] ST_CHECKSUM = 4'd4;
	localparam logic [3:0] ST_BOOT_BAD = 4'd5;
	localparam logic [3:0] ST_BOOT_OK = 4'd6;
	localparam logic [3:0] ST_EOF = 4'd7;
	localparam logic [3:0] ST_INPUT_END = 4'd8;

	localparam logic REG_LOAD_MODE = 1'b0;
	localparam logic REG_BOOT_BASE = 1'b1;

	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] TYPE_DATA = 8'h00;
	localparam logic [7:0] TYPE_EOF = 8'h01;
	localparam logic [7:0] TYPE_START_ADDR = 8'h05;
	localparam int MIN_LINE_CHARS = 11;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHAR,
		S_CHAR2,
		S_CHECK,
		S_RD_TYPE,
		S_RD_ADDR,
		S_ADDR_DONE,
		S_DATA_RD,
		S_DATA_OUT,
		S_PAGE_OUT,
		S_EOF_OUT,
		S_STATUS_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [10:0] page_offset;
		logic [31:0] page_address;
		logic [10:0] write_halfwords;
		logic [3:0]  status;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] text_char;
	} item_t;

	function automatic logic [7:0] nibble_of(input logic [7:0] c);
		logic [7:0] n;
		if (c >= 8'h30 && c <= 8'h39) n = c - 8'h30;
		else if (c >= 8'h61 && c <= 8'h66) n = c - 8'h57;
		else if (c >= 8'h41 && c <= 8'h46) n = c - 8'h37;
		else n = c;
		return n;
	endfunction

endpackage

### rtl/ihex_if.sv
interface ihex_item_if;
	logic valid;
	logic ready;
	ihex_pkg::item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ihex_result_if;
	logic valid;
	logic ready;
	ihex_pkg::result_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ihex_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/intel_hex_record_loader_core.sv
// channel   dir  payload
// in        in   func, text_char
// out       out  kind, data_byte, page_offset, page_address, write_halfwords, status, last
// cfg       in   index (0 load_mode, 1 boot_base), data
// A text character updates the line state; each second hex digit writes a record byte.
// A held CR is taken first. A line end gives a data result per byte, a page result per filled
// page, or a boot address check, to the status; the next request waits until it is taken.
// Results leave through one output register; a stalled output holds the sequencer.
// Reset is asynchronous; the record buffer is not cleared.
module intel_hex_record_loader_core #(
	parameter int PAGE_BYTES = ihex_pkg::PAGE_BYTES_DEF,
	parameter int MAX_LINE_CHARS = ihex_pkg::MAX_LINE_CHARS_DEF,
	parameter int RECORD_BUF_BYTES = ihex_pkg::RECORD_BUF_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	ihex_item_if.sink in,
	ihex_result_if.source out,
	ihex_cfg_if.sink cfg
);
	localparam int CW = $clog2(MAX_LINE_CHARS + 1);
	localparam int AW = $clog2(RECORD_BUF_BYTES);
	localparam int PW = $clog2(PAGE_BYTES + 1);
	localparam int RW = $clog2(ihex_pkg::RESULT_ROOM + 1);
	localparam int CAPN = RECORD_BUF_BYTES - 4;
	localparam int CNW = $clog2(RECORD_BUF_BYTES + 256);

	ihex_pkg::state_t state_q, state_d;
	logic load_mode_q;
	logic [31:0] boot_base_q;
	logic [CW-1:0] char_count_q;
	logic [7:0] high_nibble_q, first_char_q, running_sum_q;
	logic cr_seen_q, halted_q;
	logic [PW-1:0] page_fill_q;
	logic [15:0] page_number_q;
	logic [31:0] page_addr_q;
	logic [7:0] char_q;
	logic [7:0] char2_q;
	logic [7:0] mem [RECORD_BUF_BYTES];
	logic [7:0] rd_s1;
	logic [3:0] status_q;
	logic [31:0] addr_q;
	logic [2:0] addr_idx_q;
	logic [CNW-1:0] cnt_q, idx_q;
	logic [RW-1:0] emitted_q;
	logic out_valid_q;
	ihex_pkg::result_t out_q;

	logic out_free, start_char2;
	assign out_free = !out_valid_q || out.ready;
	assign out.valid = out_valid_q;
	assign out.payload = out_q;
	assign cfg.ready = 1'b1;
	assign in.ready = (state_q == ihex_pkg::S_IDLE) && !out_valid_q;

	// memory access
	logic mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [7:0] mem_wd;
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_s1 <= mem[mem_ra];
	end

	// char taking combinational
	logic take_here;
	logic [7:0] byte_val;
	logic [CW-1:0] pidx;
	always_comb begin
		byte_val = 8'((high_nibble_q << 4) + ihex_pkg::nibble_of(char_q));
		pidx = CW'(char_count_q >> 1) - CW'(1);
		mem_wa = pidx[AW-1:0];
		mem_wd = byte_val;
		take_here = (state_q == ihex_pkg::S_CHAR || state_q == ihex_pkg::S_CHAR2)
			&& (char_count_q < CW'(MAX_LINE_CHARS)) && char_count_q != '0 && !char_count_q[0];
		mem_we = take_here && (32'(pidx) < RECORD_BUF_BYTES);
	end

	always_comb begin
		mem_ra = '0;
		case (state_q)
			ihex_pkg::S_CHECK: mem_ra = AW'(3);
			ihex_pkg::S_RD_TYPE: mem_ra = AW'(4);
			ihex_pkg::S_RD_ADDR: mem_ra = AW'(32'(addr_idx_q) + 5);
			ihex_pkg::S_DATA_RD, ihex_pkg::S_DATA_OUT: mem_ra = AW'(32'(idx_q) + 4);
			default: mem_ra = '0;
		endcase
	end

	// status at line end
	logic [3:0] line_st;
	always_comb begin
		if (char_count_q >= CW'(MAX_LINE_CHARS)) line_st = ihex_pkg::ST_LONG;
		else if (char_count_q == '0 || first_char_q != ihex_pkg::CH_COLON)
			line_st = ihex_pkg::ST_NO_COLON;
		else if (char_count_q < CW'(ihex_pkg::MIN_LINE_CHARS)) line_st = ihex_pkg::ST_SHORT;
		else if (running_sum_q != 8'd0) line_st = ihex_pkg::ST_CHECKSUM;
		else line_st = ihex_pkg::ST_OK;
	end

	logic [CNW-1:0] avail;
	always_comb begin
		avail = CNW'(((char_count_q - CW'(1)) >> 1)) - CNW'(5);
	end

	// byte count is shadowed from writes to entry 0
	logic [7:0] bc_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bc_q <= '0;
		else if (mem_we && mem_wa == '0) bc_q <= mem_wd;
	end
	logic [CNW-1:0] cnt_eff;
	always_comb begin
		cnt_eff = CNW'(bc_q);
		if (cnt_eff > avail) cnt_eff = avail;
		if (cnt_eff > CNW'(CAPN)) cnt_eff = CNW'(CAPN);
	end

	// a held CR is taken first, then the character that followed it
	assign start_char2 = char2_q != ihex_pkg::CH_CR;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ihex_pkg::S_IDLE: begin
				if (in.valid && in.ready && !halted_q) begin
					if (in.payload.func == ihex_pkg::FUNC_END) state_d = ihex_pkg::S_STATUS_OUT;
					else if (in.payload.func == ihex_pkg::FUNC_CHAR) begin
						if (in.payload.text_char == ihex_pkg::CH_LF && cr_seen_q)
							state_d = ihex_pkg::S_CHECK;
						else if (cr_seen_q) state_d = ihex_pkg::S_CHAR;
						else if (in.payload.text_char != ihex_pkg::CH_CR)
							state_d = ihex_pkg::S_CHAR2;
					end
				end
			end
			ihex_pkg::S_CHAR: state_d = start_char2 ? ihex_pkg::S_CHAR2 : ihex_pkg::S_IDLE;
			ihex_pkg::S_CHAR2: state_d = ihex_pkg::S_IDLE;
			ihex_pkg::S_CHECK: state_d = ihex_pkg::S_RD_TYPE;
			ihex_pkg::S_RD_TYPE: begin
				if (status_q != ihex_pkg::ST_OK) state_d = ihex_pkg::S_STATUS_OUT;
				else if (!load_mode_q) begin
					state_d = (rd_s1 == ihex_pkg::TYPE_START_ADDR) ? ihex_pkg::S_RD_ADDR
						: ihex_pkg::S_STATUS_OUT;
				end else if (rd_s1 == ihex_pkg::TYPE_EOF) state_d = ihex_pkg::S_EOF_OUT;
				else if (rd_s1 == ihex_pkg::TYPE_DATA) state_d = ihex_pkg::S_DATA_RD;
				else state_d = ihex_pkg::S_STATUS_OUT;
			end
			ihex_pkg::S_RD_ADDR: if (addr_idx_q == 3'd3) state_d = ihex_pkg::S_ADDR_DONE;
			ihex_pkg::S_ADDR_DONE: state_d = ihex_pkg::S_STATUS_OUT;
			ihex_pkg::S_DATA_RD:
				state_d = (idx_q >= cnt_q) ? ihex_pkg::S_STATUS_OUT : ihex_pkg::S_DATA_OUT;
			ihex_pkg::S_DATA_OUT: if (out_free) begin
				state_d = (32'(page_fill_q) + 1 >= PAGE_BYTES) ? ihex_pkg::S_PAGE_OUT
					: ihex_pkg::S_DATA_RD;
			end
			ihex_pkg::S_PAGE_OUT: if (out_free) state_d = ihex_pkg::S_DATA_RD;
			ihex_pkg::S_EOF_OUT: if (out_free) state_d = ihex_pkg::S_STATUS_OUT;
			ihex_pkg::S_STATUS_OUT: if (out_free) state_d = ihex_pkg::S_IDLE;
			default: state_d = ihex_pkg::S_IDLE;
		endcase
	end

	// result to be loaded this cycle
	logic emit_now;
	ihex_pkg::result_t res;
	always_comb begin
		res = '0;
		emit_now = 1'b0;
		case (state_q)
			ihex_pkg::S_DATA_OUT: begin
				emit_now = out_free;
				res.kind = ihex_pkg::KIND_DATA;
				res.data_byte = rd_s1;
				res.page_offset = 11'(page_fill_q);
				res.page_address = page_addr_q;
			end
			ihex_pkg::S_PAGE_OUT: begin
				emit_now = out_free;
				res.kind = ihex_pkg::KIND_PAGE;
				res.page_address = page_addr_q;
				res.write_halfwords = 11'(PAGE_BYTES / 2);
			end
			ihex_pkg::S_EOF_OUT: begin
				emit_now = out_free;
				res.kind = ihex_pkg::KIND_PAGE;
				res.page_address = page_addr_q;
				res.write_halfwords = 11'((32'(page_fill_q) + 1) >> 1);
			end
			ihex_pkg::S_STATUS_OUT: begin
				emit_now = out_free;
				res.kind = ihex_pkg::KIND_STATUS;
				res.status = status_q;
				res.last = 1'b1;
			end
			default: ;
		endcase
		// the last result that fits closes the item
		if (32'(emitted_q) == ihex_pkg::RESULT_ROOM - 1) res.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ihex_pkg::S_IDLE;
			load_mode_q <= 1'b0;
			boot_base_q <= '0;
			char_count_q <= '0;
			high_nibble_q <= '0;
			first_char_q <= '0;
			running_sum_q <= '0;
			cr_seen_q <= 1'b0;
			halted_q <= 1'b0;
			page_fill_q <= '0;
			page_number_q <= '0;
			page_addr_q <= '0;
			out_valid_q <= 1'b0;
			emitted_q <= '0;
			status_q <= ihex_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				if (cfg.index == ihex_pkg::REG_LOAD_MODE) load_mode_q <= cfg.data[0];
				else begin
					boot_base_q <= cfg.data;
					page_addr_q <= cfg.data + 32'(page_number_q) * 32'(PAGE_BYTES);
				end
			end
			// only the first RESULT_ROOM results of an item leave the block
			if (emit_now && 32'(emitted_q) < ihex_pkg::RESULT_ROOM) begin
				out_valid_q <= 1'b1;
				out_q <= res;
				emitted_q <= emitted_q + RW'(1);
			end else if (out_valid_q && out.ready) out_valid_q <= 1'b0;
			case (state_q)
				ihex_pkg::S_IDLE: begin
					emitted_q <= '0;
					if (in.valid && in.ready) begin
						if (in.payload.func == ihex_pkg::FUNC_START) begin
							char_count_q <= '0; high_nibble_q <= '0; first_char_q <= '0;
							running_sum_q <= '0; cr_seen_q <= 1'b0; halted_q <= 1'b0;
							page_fill_q <= '0; page_number_q <= '0; page_addr_q <= boot_base_q;
						end else if (!halted_q && in.payload.func == ihex_pkg::FUNC_END) begin
							char_count_q <= '0; high_nibble_q <= '0; first_char_q <= '0;
							running_sum_q <= '0; cr_seen_q <= 1'b0;
							status_q <= ihex_pkg::ST_INPUT_END;
						end else if (!halted_q && in.payload.func == ihex_pkg::FUNC_CHAR) begin
							char_q <= cr_seen_q ? ihex_pkg::CH_CR : in.payload.text_char;
							char2_q <= in.payload.text_char;
							cr_seen_q <= (in.payload.text_char == ihex_pkg::CH_CR);
						end
					end
				end
				ihex_pkg::S_CHAR, ihex_pkg::S_CHAR2: begin
					if (char_count_q < CW'(MAX_LINE_CHARS)) begin
						if (char_count_q == '0) first_char_q <= char_q;
						else if (char_count_q[0]) high_nibble_q <= ihex_pkg::nibble_of(char_q);
						else running_sum_q <= running_sum_q + byte_val;
						char_count_q <= char_count_q + CW'(1);
					end
					if (state_q == ihex_pkg::S_CHAR) char_q <= char2_q;
				end
				ihex_pkg::S_CHECK: status_q <= line_st;
				ihex_pkg::S_RD_TYPE: begin
					addr_idx_q <= '0;
					idx_q <= '0;
					cnt_q <= cnt_eff;
					if (status_q == ihex_pkg::ST_OK && load_mode_q
						&& rd_s1 == ihex_pkg::TYPE_EOF) status_q <= ihex_pkg::ST_EOF;
				end
				ihex_pkg::S_RD_ADDR: begin
					addr_q <= {addr_q[23:0], rd_s1};
					addr_idx_q <= addr_idx_q + 3'd1;
				end
				ihex_pkg::S_ADDR_DONE: begin
					status_q <= ((addr_q & boot_base_q) == boot_base_q)
						? ihex_pkg::ST_BOOT_OK : ihex_pkg::ST_BOOT_BAD;
				end
				ihex_pkg::S_DATA_OUT: if (out_free) begin
					idx_q <= idx_q + CNW'(1);
					if (32'(page_fill_q) + 1 >= PAGE_BYTES) page_fill_q <= page_fill_q + PW'(1);
					else page_fill_q <= page_fill_q + PW'(1);
				end
				ihex_pkg::S_PAGE_OUT: if (out_free) begin
					page_fill_q <= '0;
					page_number_q <= page_number_q + 16'd1;
					// page number wraps at 16 bits, the address follows it
					page_addr_q <= (page_number_q == 16'hffff) ? boot_base_q
						: page_addr_q + 32'(PAGE_BYTES);
				end
				ihex_pkg::S_STATUS_OUT: if (out_free) begin
					char_count_q <= '0; high_nibble_q <= '0; first_char_q <= '0;
					running_sum_q <= '0;
					if (status_q >= ihex_pkg::ST_NO_COLON && status_q <= ihex_pkg::ST_BOOT_BAD)
						halted_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end
endmodule

### rtl/ihex_checker.sv
module ihex_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] out_kind,
	input logic [3:0] out_status,
	input logic out_last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("output dropped");
	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_kind == ihex_pkg::KIND_STATUS) else $error("last kind");
	a_no_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while busy");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == ihex_pkg::KIND_STATUS |-> out_last) else $error("status last");
endmodule

bind intel_hex_record_loader_core ihex_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in.valid), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready), .out_kind(out.payload.kind),
	.out_status(out.payload.status), .out_last(out.payload.last)
);

### dv/intel_hex_record_loader_core_tb.sv
module intel_hex_record_loader_core_tb;
	import ihex_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAGE_SZ = PAGE_BYTES_DEF;
	localparam int LINE_MAX = MAX_LINE_CHARS_DEF;
	localparam int BUF_SZ = RECORD_BUF_BYTES_DEF;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 3000;
	localparam int NO_RESULT = -2;
	localparam int BY_MODEL = -1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ihex_item_if in_if ();
	ihex_result_if out_if ();
	ihex_cfg_if cfg_if ();

	intel_hex_record_loader_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_if),
		.out(out_if),
		.cfg(cfg_if)
	);

	always #10 clk = ~clk;

	// loader state mirror
	logic        m_load;
	logic [31:0] m_base;
	logic [7:0]  m_rec [BUF_SZ];
	int          m_chars;
	logic [7:0]  m_hi;
	logic [7:0]  m_first;
	logic        m_cr;
	logic [7:0]  m_sum;
	int          m_fill;
	logic [15:0] m_page;
	logic        m_halt;

	item_t   char_q [$];
	result_t burst_q [$];
	result_t expected_q [$];

	int errors = 0;
	int result_cnt = 0;
	logic [3:0] last_status = ST_OK;
	bit calm = 0;
	bit hold_req = 0;
	int idle_cycles = 0;

	task automatic report(string what, longint got, longint want);
		$display("mismatch %0s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm) return 0;
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] hex_val(logic [7:0] c);
		if (c >= "0" && c <= "9") return c - 8'h30;
		if (c >= "a" && c <= "f") return c - 8'h57;
		if (c >= "A" && c <= "F") return c - 8'h37;
		return c;
	endfunction

	function automatic logic [7:0] rec_at(int i);
		return (i < BUF_SZ) ? m_rec[i] : 8'h00;
	endfunction

	function automatic logic [31:0] page_addr();
		return m_base + {16'h0, m_page} * PAGE_SZ;
	endfunction

	task automatic clear_line();
		m_chars = 0;
		m_hi = 0;
		m_first = 0;
		m_cr = 0;
		m_sum = 0;
	endtask

	task automatic push_res(logic [1:0] k, logic [7:0] d, logic [10:0] off, logic [31:0] a,
			logic [10:0] hw, logic [3:0] st);
		result_t r;
		r = '0;
		r.kind = k;
		r.data_byte = d;
		r.page_offset = off;
		r.page_address = a;
		r.write_halfwords = hw;
		r.status = st;
		if (burst_q.size() < RESULT_ROOM) burst_q.push_back(r);
	endtask

	task automatic take_char(logic [7:0] c);
		int p;
		logic [7:0] b;
		p = m_chars;
		if (p >= LINE_MAX) return;
		if (p == 0) m_first = c;
		else if (p % 2) m_hi = hex_val(c);
		else begin
			b = m_hi * 16 + hex_val(c);
			if (p / 2 - 1 < BUF_SZ) m_rec[p / 2 - 1] = b;
			m_sum += b;
		end
		m_chars = p + 1;
	endtask

	task automatic close_line();
		int len;
		int cnt;
		int avail;
		logic [3:0] st;
		logic [31:0] a;
		len = m_chars;
		st = ST_OK;
		if (len >= LINE_MAX) st = ST_LONG;
		else if (len == 0 || m_first != CH_COLON) st = ST_NO_COLON;
		else if (len < MIN_LINE_CHARS) st = ST_SHORT;
		else if (m_sum != 0) st = ST_CHECKSUM;
		if (st == ST_OK) begin
			if (!m_load) begin
				if (rec_at(3) == TYPE_START_ADDR) begin
					a = {rec_at(4), rec_at(5), rec_at(6), rec_at(7)};
					st = ((a & m_base) == m_base) ? ST_BOOT_OK : ST_BOOT_BAD;
				end
			end else if (rec_at(3) == TYPE_DATA) begin
				cnt = rec_at(0);
				avail = (len - 1) / 2 - 5;
				if (cnt > avail) cnt = avail;
				if (cnt > BUF_SZ - 4) cnt = BUF_SZ - 4;
				for (int i = 0; i < cnt; i++) begin
					push_res(KIND_DATA, rec_at(4 + i), m_fill[10:0], page_addr(), 0, ST_OK);
					m_fill++;
					if (m_fill >= PAGE_SZ) begin
						push_res(KIND_PAGE, 0, 0, page_addr(), PAGE_SZ / 2, ST_OK);
						m_fill = 0;
						m_page++;
					end
				end
			end else if (rec_at(3) == TYPE_EOF) begin
				push_res(KIND_PAGE, 0, 0, page_addr(), (m_fill + 1) / 2, ST_OK);
				st = ST_EOF;
			end
		end
		push_res(KIND_STATUS, 0, 0, 0, 0, st);
		if (st >= ST_NO_COLON && st <= ST_BOOT_BAD) m_halt = 1;
		clear_line();
	endtask

	task automatic predict(item_t it);
		burst_q.delete();
		if (it.func == FUNC_START) begin
			clear_line();
			m_fill = 0;
			m_page = 0;
			m_halt = 0;
			return;
		end
		if (m_halt || it.func == 2'd3) return;
		if (it.func == FUNC_END) begin
			clear_line();
			push_res(KIND_STATUS, 0, 0, 0, 0, ST_INPUT_END);
		end else if (it.text_char == CH_CR) begin
			if (m_cr) take_char(CH_CR);
			m_cr = 1;
		end else if (it.text_char == CH_LF && m_cr) begin
			m_cr = 0;
			close_line();
		end else begin
			if (m_cr) take_char(CH_CR);
			m_cr = 0;
			take_char(it.text_char);
		end
		if (burst_q.size() > 0) burst_q[burst_q.size() - 1].last = 1'b1;
		foreach (burst_q[i]) expected_q.push_back(burst_q[i]);
	endtask

	// request driver
	int in_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
			in_if.payload <= '0;
		end else begin
			if (in_if.valid && in_if.ready) predict(in_if.payload);
			if (!in_if.valid || in_if.ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_if.valid <= 1'b0;
				end else if (char_q.size() > 0) begin
					in_if.payload <= char_q.pop_front();
					in_if.valid <= 1'b1;
					in_gap = pick_gap();
				end else begin
					in_if.valid <= 1'b0;
				end
			end
		end
	end

	// result receiver with random stalls and one long hold-off
	int out_stall = 0;
	int hold_cnt = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
		end else begin
			if (hold_req) begin
				hold_req = 0;
				hold_cnt = HOLD_CYCLES;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_if.ready <= 1'b0;
			end else if (out_stall > 0) begin
				out_stall--;
				out_if.ready <= 1'b0;
			end else begin
				out_if.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) out_stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			got = out_if.payload;
			result_cnt++;
			if (got.kind == KIND_STATUS) last_status = got.status;
			if (expected_q.size() == 0) begin
				report("unexpected result kind", got.kind, 0);
			end else begin
				want = expected_q.pop_front();
				if (got.kind != want.kind) report("kind", got.kind, want.kind);
				if (got.data_byte != want.data_byte)
					report("data_byte", got.data_byte, want.data_byte);
				if (got.page_offset != want.page_offset)
					report("page_offset", got.page_offset, want.page_offset);
				if (got.page_address != want.page_address)
					report("page_address", got.page_address, want.page_address);
				if (got.write_halfwords != want.write_halfwords)
					report("write_halfwords", got.write_halfwords, want.write_halfwords);
				if (got.status != want.status) report("status", got.status, want.status);
				if (got.last != want.last) report("last", got.last, want.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
				(cfg_if.valid && cfg_if.ready)) begin
			idle_cycles = 0;
		end else if (arst_n) begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic push_text(string s);
		item_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.func = FUNC_CHAR;
			it.text_char = s[i];
			char_q.push_back(it);
		end
	endtask

	task automatic push_line(string s);
		push_text({s, "\015\012"});
	endtask

	task automatic push_func(logic [1:0] f);
		item_t it;
		it.func = f;
		it.text_char = $urandom_range(0, 255);
		char_q.push_back(it);
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (char_q.size() > 0 || in_if.valid || expected_q.size() > 0);
		repeat (100) @(posedge clk);
	endtask

	task automatic cfg_write(logic idx, logic [31:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		do @(posedge clk);
		while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		if (idx == REG_LOAD_MODE) m_load = val[0];
		else m_base = val;
		@(posedge clk);
	endtask

	function automatic string mk_record(logic [7:0] b [$], bit bad_sum, bit lower);
		string s;
		logic [7:0] sum;
		s = ":";
		sum = 0;
		foreach (b[i]) sum += b[i];
		b.push_back(-sum + (bad_sum ? 8'd1 : 8'd0));
		foreach (b[i]) s = {s, lower ? $sformatf("%02x", b[i]) : $sformatf("%02X", b[i])};
		return s;
	endfunction

	task automatic gen_record(bit heavy);
		logic [7:0] b [$];
		logic [31:0] a;
		string s;
		string pool;
		int r;
		int n;
		bit lower;
		r = heavy ? $urandom_range(0, 50) : $urandom_range(0, 99);
		lower = $urandom_range(0, 1);
		pool = ":0123456789abcdefABCDEF\015\012";
		if (r < 45) begin
			n = $urandom_range(0, 24);
			b.push_back(($urandom_range(0, 7) == 0) ? $urandom_range(n + 1, 255) : n);
			b.push_back($urandom_range(0, 255));
			b.push_back($urandom_range(0, 255));
			b.push_back(TYPE_DATA);
			repeat (n) b.push_back($urandom_range(0, 255));
			push_line(mk_record(b, 0, lower));
		end else if (r < 55) begin
			push_line(mk_record('{8'h00, 8'h00, 8'h00, TYPE_EOF}, 0, lower));
		end else if (r < 65) begin
			a = $urandom_range(0, 1) ? (m_base | $urandom()) : $urandom();
			b = '{8'h04, 8'h00, 8'h00, TYPE_START_ADDR};
			for (int i = 3; i >= 0; i--) b.push_back(a[i*8 +: 8]);
			push_line(mk_record(b, 0, lower));
		end else if (r < 70) begin
			b = '{8'h00, 8'h00, 8'h00};
			b.push_back($urandom_range(2, 255));
			repeat ($urandom_range(0, 4)) b.push_back($urandom_range(0, 255));
			b[0] = b.size() - 4;
			push_line(mk_record(b, 0, lower));
		end else if (r < 78) begin
			b = '{8'h02, 8'h12, 8'h34, TYPE_DATA, 8'hab, 8'hcd};
			push_line(mk_record(b, 1, lower));
			push_func(FUNC_START);
		end else if (r < 90) begin
			s = $urandom_range(0, 1) ? ":" : "";
			n = $urandom_range(0, 66);
			repeat (n) begin
				if ($urandom_range(0, 2) == 0) s = {s, string'(8'($urandom_range(0, 255)))};
				else s = {s, string'(pool[$urandom_range(0, pool.len() - 1)])};
			end
			push_line(s);
			push_func(FUNC_START);
		end else if (r < 94) begin
			push_func(FUNC_END);
		end else if (r < 96) begin
			push_func(2'd3);
		end else begin
			push_func(FUNC_START);
		end
		if ($urandom_range(0, 3) == 0) push_func(FUNC_START);
	endtask

	typedef struct {
		logic [1:0] func;
		string      text;
		int         want;
	} dir_row_t;

	dir_row_t dir_rows [] = '{
		// first line writes record buffer bytes 0 to 28 so later short records read written bytes
		'{FUNC_CHAR, {":", {69{"1"}}}, ST_LONG},
		'{FUNC_CHAR, ":00000001FF", NO_RESULT},
		'{FUNC_START, "", NO_RESULT},
		'{FUNC_CHAR, "", ST_NO_COLON},
		'{FUNC_START, "", NO_RESULT},
		'{FUNC_CHAR, "X0000001FF0", ST_NO_COLON},
		'{FUNC_START, "", NO_RESULT},
		'{FUNC_CHAR, ":0000", ST_SHORT},
		'{FUNC_START, "", NO_RESULT},
		'{FUNC_CHAR, ":0000000001", ST_CHECKSUM},
		'{FUNC_START, "", NO_RESULT},
		'{FUNC_CHAR, ":00000001FF", ST_OK},
		'{FUNC_CHAR, ":0400000500000000F7", ST_BOOT_OK},
		'{FUNC_CHAR, ":00000001ff", ST_OK},
		'{FUNC_END, "", ST_INPUT_END},
		'{2'd3, "", NO_RESULT},
		'{FUNC_CHAR, ":00000001FF0", BY_MODEL},
		'{FUNC_CHAR, ":00\0150\015001FF", BY_MODEL},
		'{FUNC_CHAR, ":0G000001FF", BY_MODEL},
		'{FUNC_CHAR, {":FF", {56{"F"}}}, BY_MODEL},
		'{FUNC_START, "", NO_RESULT}
	};

	logic        ph_load [6] = '{0, 0, 0, 1, 1, 1};
	logic [31:0] ph_base [6];
	int          ph_lines [6] = '{1, 1, 1, 2, 1, 1};

	initial begin
		int count_prior;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= REG_LOAD_MODE;
		cfg_if.data <= '0;
		m_load = 0;
		m_base = 0;
		foreach (m_rec[i]) m_rec[i] = 0;
		clear_line();
		m_fill = 0;
		m_page = 0;
		m_halt = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			count_prior = result_cnt;
			if (dir_rows[i].func == FUNC_CHAR) push_line(dir_rows[i].text);
			else push_func(dir_rows[i].func);
			wait_drained();
			if (dir_rows[i].want == NO_RESULT && result_cnt != count_prior)
				report($sformatf("row %0d result count", i), result_cnt - count_prior, 0);
			else if (dir_rows[i].want >= 0 && last_status != dir_rows[i].want)
				report($sformatf("row %0d status", i), last_status, dir_rows[i].want);
		end

		ph_base = '{32'h0, 32'hffff_ffff, $urandom(), 32'h0, 32'hffff_ffff, $urandom()};
		for (int p = 0; p < 6; p++) begin
			cfg_write(REG_LOAD_MODE, {31'h0, ph_load[p]});
			cfg_write(REG_BOOT_BASE, ph_base[p]);
			calm = (p == 2);
			push_func(FUNC_START);
			for (int k = 0; k < ph_lines[p]; k++) gen_record(p == 3);
			if (p == 4) begin
				// long hold-off while a further random record is still being sent
				for (int k = 0; k < 1; k++) gen_record(1);
				hold_req = 1;
			end
			wait_drained();
		end

		if (errors == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

endmodule

### filelist.f
rtl/ihex_pkg.sv
rtl/ihex_if.sv
rtl/intel_hex_record_loader_core.sv
rtl/ihex_checker.sv
dv/intel_hex_record_loader_core_tb.sv
